@@ hw/rtl/bps_pkg.sv @@
// bps_pkg: shared types, widths and codes of the bilinear plane scaler.
// Used by bps_map and bilinear_plane_scaler; depends on nothing.
package bps_pkg;

   localparam int DEF_MAX_SRC_WIDTH = 2048;
   localparam int DEF_FRAC_BITS     = 16;
   localparam int DEF_MAX_UPSCALE   = 4;

   localparam int DIM_W      = 13;   // destination sizes and positions
   localparam int SRC_DIM_W  = 12;   // source size registers
   localparam int SRC_SIZE_W = 14;   // clamped source size, up to 4095
   localparam int STEP_W     = 19;
   localparam int CSR_W      = 19;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SRC_WIDTH,
      CSR_SRC_HEIGHT,
      CSR_DST_WIDTH,
      CSR_DST_HEIGHT,
      CSR_STEP_X,
      CSR_STEP_Y,
      CSR_CHROMA_MODE
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW_REQ,
      ST_ROW_M1,
      ST_ROW_CHK,
      ST_COL_REQ,
      ST_COL_M1,
      ST_COL_CHK,
      ST_BLEND,
      ST_OUT,
      ST_END,
      ST_RB_REQ,
      ST_RB_M1,
      ST_RB_CHK
   } state_type;

   // one coordinate mapping request
   typedef struct packed {
      logic [DIM_W-1:0]      d;
      logic [DIM_W-1:0]      dsz;
      logic [STEP_W-1:0]     step;
      logic [SRC_SIZE_W-1:0] ssz;
   } map_req_type;

endpackage

@@ hw/rtl/bps_ram.sv @@
// bps_ram: generic single-port-write, single-port-read RAM, registered read.
// Depends on nothing.
module bps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];   // read-first on same address
      end
   end

endmodule

@@ hw/rtl/bps_map.sv @@
// bps_map: two-stage destination-to-source coordinate mapper with clamping.
// Depends on bps_pkg.
module bps_map
   import bps_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  map_req_type           req,
   output logic [SRC_SIZE_W-1:0] lo_ff,
   output logic [SRC_SIZE_W-1:0] hi_ff,
   output logic [FRAC_BITS-1:0]  frac_ff
);

   localparam int PW = DIM_W + 1 + STEP_W + 1;
   localparam int CW = SRC_SIZE_W + FRAC_BITS;
   localparam int QW = ((PW > CW) ? PW : CW) + 1;

   logic signed [DIM_W:0]   diff;
   logic signed [PW-1:0]    prod_ff;
   logic [CW-1:0]           base_ff;
   logic [CW-1:0]           maxq_ff;
   logic [SRC_SIZE_W-1:0]   ssz_ff;
   logic signed [QW-1:0]    q;
   logic [CW-1:0]           qc;
   logic [SRC_SIZE_W-1:0]   lo;
   logic [SRC_SIZE_W:0]     lo_p1;

   assign diff = signed'({1'b0, req.d}) - signed'({2'b00, req.dsz[DIM_W-1:1]});

   always_ff @(posedge clock) begin
      prod_ff <= diff * signed'({1'b0, req.step});
      base_ff <= {1'b0, req.ssz[SRC_SIZE_W-1:1], {FRAC_BITS{1'b0}}};
      maxq_ff <= {req.ssz - SRC_SIZE_W'(1), {FRAC_BITS{1'b0}}};
      ssz_ff  <= req.ssz;
   end

   always_comb begin
      q = QW'(prod_ff) + signed'(QW'(base_ff));
      if (q < 0) begin
         qc = '0;
      end else if (q > signed'(QW'(maxq_ff))) begin
         qc = maxq_ff;
      end else begin
         qc = q[CW-1:0];
      end
      lo    = qc[FRAC_BITS +: SRC_SIZE_W];
      lo_p1 = {1'b0, lo} + (SRC_SIZE_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo;
      frac_ff <= qc[FRAC_BITS-1:0];
      hi_ff   <= (lo_p1 < {1'b0, ssz_ff}) ? lo_p1[SRC_SIZE_W-1:0]
                                          : ssz_ff - SRC_SIZE_W'(1);
   end

endmodule

@@ hw/rtl/bilinear_plane_scaler.sv @@
// bilinear_plane_scaler: streaming bilinear scaler of one image plane.
// Depends on bps_pkg, bps_ram (line store) and bps_map (coordinate mapper).
//
//   channel | dir | handshake           | payload
//   req     | in  | tvalid/tready       | tdata: sample_a, sample_b; tuser: frame_start
//   rsp     | out | tvalid/tready/tlast | tdata: value_a, value_b, dst_col, dst_line
//   csr     | in  | we                  | addr, wdata
//
// One item at a time. Per item: an accept, a mapper evaluation of each candidate
// destination row and column (a scan stops at its count or size limit), six passes
// per result through the shared interpolation multiplier and an output step, an end
// step, and at the end of a source row a check of destination rows until the limit.
// Reset is synchronous; the line store is not cleared, a fill count makes
// unwritten entries read as zero. A stalled rsp holds the sequencer in OUT.
module bilinear_plane_scaler
   import bps_pkg::*;
#(
   parameter int MAX_SRC_WIDTH = DEF_MAX_SRC_WIDTH,
   parameter int FRAC_BITS     = DEF_FRAC_BITS,
   parameter int MAX_UPSCALE   = DEF_MAX_UPSCALE
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [7:0] sample_a, [15:8] sample_b
   input  logic                  req_tuser,   // [0] frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // [7:0] value_a, [15:8] value_b,
                                              // [28:16] dst_col, [41:29] dst_line
   output logic                  rsp_tlast,   // run_end
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int CNW = $clog2(MAX_SRC_WIDTH);
   localparam int FW  = $clog2(MAX_SRC_WIDTH + 1);
   localparam int CW  = $clog2(MAX_UPSCALE + 1);
   localparam int UW  = (MAX_UPSCALE > 1) ? $clog2(MAX_UPSCALE) : 1;
   localparam int XW  = 8 + FRAC_BITS;
   localparam int LRW = XW + FRAC_BITS;

   // configuration
   logic [SRC_DIM_W-1:0] src_width_ff, src_height_ff;
   logic [DIM_W-1:0]     dst_width_ff, dst_height_ff;
   logic [STEP_W-1:0]    step_x_ff, step_y_ff;
   logic                 chroma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_DIM_W'(1920);
         src_height_ff <= SRC_DIM_W'(1080);
         dst_width_ff  <= DIM_W'(2400);
         dst_height_ff <= DIM_W'(1344);
         step_x_ff     <= STEP_W'(52429);
         step_y_ff     <= STEP_W'(52663);
         chroma_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_SRC_WIDTH:   src_width_ff  <= csr_wdata[SRC_DIM_W-1:0];
            CSR_SRC_HEIGHT:  src_height_ff <= csr_wdata[SRC_DIM_W-1:0];
            CSR_DST_WIDTH:   dst_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_DST_HEIGHT:  dst_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_STEP_X:      step_x_ff     <= csr_wdata[STEP_W-1:0];
            CSR_STEP_Y:      step_y_ff     <= csr_wdata[STEP_W-1:0];
            CSR_CHROMA_MODE: chroma_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamped source size
   logic [SRC_SIZE_W-1:0] eff_w, eff_h;
   always_comb begin
      if (src_width_ff < SRC_DIM_W'(2)) begin
         eff_w = SRC_SIZE_W'(2);
      end else if (SRC_SIZE_W'(src_width_ff) > SRC_SIZE_W'(MAX_SRC_WIDTH)) begin
         eff_w = SRC_SIZE_W'(MAX_SRC_WIDTH);
      end else begin
         eff_w = SRC_SIZE_W'(src_width_ff);
      end
      eff_h = (src_height_ff < SRC_DIM_W'(2)) ? SRC_SIZE_W'(2) : SRC_SIZE_W'(src_height_ff);
   end

   // state
   state_type            state_ff, state_in;
   logic [CNW-1:0]       col_ff;
   logic [SRC_DIM_W-1:0] row_ff;
   logic [DIM_W-1:0]     row_base_ff, col_base_ff;
   logic [FW-1:0]        fill_ff;
   logic                 up_valid_ff;
   logic [15:0]          cur_ff, left_ff, upleft_ff;
   logic [CW-1:0]        nr_ff, nc_ff, i_ff, j_ff;
   logic [2:0]           k_ff;
   logic                 row_eq_ff [MAX_UPSCALE];
   logic [FRAC_BITS-1:0] fy_ff     [MAX_UPSCALE];
   logic                 col_eq_ff [MAX_UPSCALE];
   logic [FRAC_BITS-1:0] fx_ff     [MAX_UPSCALE];
   logic [DIM_W-1:0]     col_d_ff  [MAX_UPSCALE];
   logic [XW-1:0]        top_ff;
   logic [LRW-1:0]       lerp_ff;
   logic [7:0]           va_ff;
   logic                 rsp_tvalid_ff, rsp_tlast_ff;
   logic [47:0]          rsp_tdata_ff;

   logic           acc;
   logic [CNW-1:0] c_acc;
   logic [15:0]    cur_acc;
   logic [15:0]    ram_rdata, up;

   assign req_tready = (state_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign c_acc      = req_tuser ? '0 : col_ff;
   assign cur_acc    = {chroma_ff ? req_tdata[15:8] : 8'h00, req_tdata[7:0]};
   assign up         = up_valid_ff ? ram_rdata : 16'h0000;

   bps_ram #(
      .WIDTH (16),
      .DEPTH (MAX_SRC_WIDTH)
   ) u_line (
      .clock      (clock),
      .wr_en      (acc),
      .wr_addr    (c_acc),
      .wr_data    (cur_acc),
      .rd_en      (acc),
      .rd_addr    (c_acc),
      .rd_data_ff (ram_rdata)
   );

   // coordinate mapper, shared by row, column and row-advance scans
   map_req_type           map_req;
   logic [SRC_SIZE_W-1:0] map_lo, map_hi;
   logic [FRAC_BITS-1:0]  map_frac;
   logic [DIM_W:0]        row_sum;

   assign row_sum = {1'b0, row_base_ff} + (DIM_W+1)'(nr_ff);

   always_comb begin
      map_req.step = step_x_ff;
      map_req.dsz  = dst_width_ff;
      map_req.ssz  = eff_w;
      map_req.d    = col_base_ff;
      if (state_ff == ST_ROW_REQ || state_ff == ST_RB_REQ) begin
         map_req.step = step_y_ff;
         map_req.dsz  = dst_height_ff;
         map_req.ssz  = eff_h;
         map_req.d    = (state_ff == ST_ROW_REQ) ? row_sum[DIM_W-1:0] : row_base_ff;
      end
   end

   bps_map #(
      .FRAC_BITS (FRAC_BITS)
   ) u_map (
      .clock   (clock),
      .req     (map_req),
      .lo_ff   (map_lo),
      .hi_ff   (map_hi),
      .frac_ff (map_frac)
   );

   // scan conditions
   logic row_go, row_hit, col_go, col_le, col_hit, rb_go, rb_le;
   logic emit_ok, out_free, last_i, last_j, col_wrap, row_wrap;

   always_comb begin
      row_go   = (nr_ff < CW'(MAX_UPSCALE)) && (row_sum < {1'b0, dst_height_ff});
      row_hit  = (map_hi == SRC_SIZE_W'(row_ff));
      col_go   = (col_base_ff < dst_width_ff);
      col_le   = (map_hi <= SRC_SIZE_W'(col_ff));
      col_hit  = (map_hi == SRC_SIZE_W'(col_ff)) && (nc_ff < CW'(MAX_UPSCALE));
      rb_go    = (row_base_ff < dst_height_ff);
      rb_le    = (map_hi <= SRC_SIZE_W'(row_ff));
      emit_ok  = (nr_ff != '0) && (nc_ff != '0);
      out_free = !rsp_tvalid_ff || rsp_tready;
      last_i   = ((i_ff + CW'(1)) == nr_ff);
      last_j   = ((j_ff + CW'(1)) == nc_ff);
      col_wrap = ((SRC_SIZE_W+1)'(col_ff) + (SRC_SIZE_W+1)'(1)) >= {1'b0, eff_w};
      row_wrap = ((SRC_SIZE_W+1)'(row_ff) + (SRC_SIZE_W+1)'(1)) >= {1'b0, eff_h};
   end

   // corners of the current result
   logic        ci, ri;
   logic [15:0] tl, tr, bl, br;
   always_comb begin
      ci = col_eq_ff[j_ff[UW-1:0]];
      ri = row_eq_ff[i_ff[UW-1:0]];
      br = cur_ff;
      bl = ci ? cur_ff : left_ff;
      tr = ri ? br : up;
      tl = ri ? bl : (ci ? up : upleft_ff);
   end

   // shared interpolation unit: x*(1-f) + y*f == (x << F) + (y - x) * f
   logic [XW-1:0]          lx, ly;
   logic [FRAC_BITS-1:0]   lf;
   logic signed [XW:0]     ldiff;
   logic signed [LRW+1:0]  lprod;
   logic [LRW-1:0]         lres;

   always_comb begin
      lx = '0;
      ly = '0;
      lf = fx_ff[j_ff[UW-1:0]];
      case (k_ff)
         3'd0: begin lx = XW'(tl[7:0]);  ly = XW'(tr[7:0]);  end
         3'd1: begin lx = XW'(bl[7:0]);  ly = XW'(br[7:0]);  end
         3'd3: begin lx = XW'(tl[15:8]); ly = XW'(tr[15:8]); end
         3'd4: begin lx = XW'(bl[15:8]); ly = XW'(br[15:8]); end
         3'd2, 3'd5: begin
            lx = top_ff;
            ly = lerp_ff[XW-1:0];
            lf = fy_ff[i_ff[UW-1:0]];
         end
         default: ;
      endcase
      ldiff = signed'({1'b0, ly}) - signed'({1'b0, lx});
      lprod = ldiff * signed'({1'b0, lf});
      lres  = {lx, {FRAC_BITS{1'b0}}} + lprod[LRW-1:0];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (acc) state_in = ST_ROW_REQ;
         ST_ROW_REQ: state_in = row_go ? ST_ROW_M1 : ST_COL_REQ;
         ST_ROW_M1:  state_in = ST_ROW_CHK;
         ST_ROW_CHK: state_in = row_hit ? ST_ROW_REQ : ST_COL_REQ;
         ST_COL_REQ: begin
            if (col_go) state_in = ST_COL_M1;
            else        state_in = emit_ok ? ST_BLEND : ST_END;
         end
         ST_COL_M1:  state_in = ST_COL_CHK;
         ST_COL_CHK: begin
            if (col_le) state_in = ST_COL_REQ;
            else        state_in = emit_ok ? ST_BLEND : ST_END;
         end
         ST_BLEND:   if (k_ff == 3'd5) state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = (last_i && last_j) ? ST_END : ST_BLEND;
         end
         ST_END: begin
            if (col_wrap && !row_wrap) state_in = ST_RB_REQ;
            else                       state_in = ST_IDLE;
         end
         ST_RB_REQ:  state_in = rb_go ? ST_RB_M1 : ST_IDLE;
         ST_RB_M1:   state_in = ST_RB_CHK;
         ST_RB_CHK:  state_in = rb_le ? ST_RB_REQ : ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         row_base_ff   <= '0;
         col_base_ff   <= '0;
         fill_ff       <= '0;
         up_valid_ff   <= 1'b0;
         left_ff       <= '0;
         upleft_ff     <= '0;
         nr_ff         <= '0;
         nc_ff         <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         k_ff <= (state_ff == ST_BLEND) ? k_ff + 3'd1 : 3'd0;
         // in OUT a free output register is reloaded below
         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_OUT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  if (req_tuser) begin
                     row_ff      <= '0;
                     row_base_ff <= '0;
                  end
                  col_ff <= c_acc;
                  if (c_acc == '0) col_base_ff <= '0;
                  cur_ff      <= cur_acc;
                  up_valid_ff <= (FW'(c_acc) < fill_ff);
                  if (FW'(c_acc) >= fill_ff) fill_ff <= FW'(c_acc) + FW'(1);
                  nr_ff <= '0;
                  nc_ff <= '0;
                  i_ff  <= '0;
                  j_ff  <= '0;
               end
            end
            ST_ROW_CHK: begin
               if (row_hit) begin
                  row_eq_ff[nr_ff[UW-1:0]] <= (map_lo == map_hi);
                  fy_ff[nr_ff[UW-1:0]]     <= map_frac;
                  nr_ff                    <= nr_ff + CW'(1);
               end
            end
            ST_COL_CHK: begin
               if (col_le) begin
                  if (col_hit) begin
                     col_eq_ff[nc_ff[UW-1:0]] <= (map_lo == map_hi);
                     fx_ff[nc_ff[UW-1:0]]     <= map_frac;
                     col_d_ff[nc_ff[UW-1:0]]  <= col_base_ff;
                     nc_ff                    <= nc_ff + CW'(1);
                  end
                  col_base_ff <= col_base_ff + DIM_W'(1);
               end
            end
            ST_BLEND: begin
               lerp_ff <= lres;
               if (k_ff == 3'd1 || k_ff == 3'd4) top_ff <= lerp_ff[XW-1:0];
               if (k_ff == 3'd3) va_ff <= lerp_ff[2*FRAC_BITS +: 8];
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tlast_ff  <= last_i && last_j;
                  rsp_tdata_ff  <= {6'b000000,
                                    row_base_ff + DIM_W'(i_ff),
                                    col_d_ff[j_ff[UW-1:0]],
                                    chroma_ff ? lerp_ff[2*FRAC_BITS +: 8] : 8'h00,
                                    va_ff};
                  if (last_j) begin
                     j_ff <= '0;
                     i_ff <= i_ff + CW'(1);
                  end else begin
                     j_ff <= j_ff + CW'(1);
                  end
               end
            end
            ST_END: begin
               left_ff   <= cur_ff;
               upleft_ff <= up;
               if (col_wrap) begin
                  col_ff <= '0;
                  if (row_wrap) begin
                     row_ff      <= '0;
                     row_base_ff <= '0;
                  end
               end else begin
                  col_ff <= col_ff + CNW'(1);
               end
            end
            ST_RB_REQ: begin
               if (!rb_go) row_ff <= row_ff + SRC_DIM_W'(1);
            end
            ST_RB_CHK: begin
               if (rb_le) row_base_ff <= row_base_ff + DIM_W'(1);
               else       row_ff      <= row_ff + SRC_DIM_W'(1);
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

@@ hw/rtl/bps_checker.sv @@
// bps_checker: port-level assertions on the bilinear plane scaler, and its bind.
// Depends on bilinear_plane_scaler.
module bps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("not ready for an item after reset");

   // one item at a time: busy right after an accept
   a_busy_after_acc: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while the previous one is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp item changed");

endmodule

bind bilinear_plane_scaler bps_checker u_bps_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench of bilinear_plane_scaler, with its own scaling predictor.
// Depends on bps_pkg and the RTL under hw/rtl; reads no files.
module tb
   import bps_pkg::*;
();

   localparam int  ONE       = 1 << DEF_FRAC_BITS;
   localparam int  CYC_LIMIT = 1000000;

   typedef struct {
      logic [7:0]  a;
      logic [7:0]  b;
      logic        fs;
   } pixel_in_type;

   typedef struct {
      logic [7:0]       va;
      logic [7:0]       vb;
      logic [DIM_W-1:0] col;
      logic [DIM_W-1:0] line;
      logic             last;
   } scaled_px_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;
   logic                  req_tuser = 0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [47:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   bilinear_plane_scaler dut (.*);

   always #1 clock = ~clock;

   // predictor copy of configuration and state
   int unsigned    m_src_w = 1920, m_src_h = 1080, m_dst_w = 2400, m_dst_h = 1344;
   int unsigned    m_step_x = 52429, m_step_y = 52663, m_chroma = 0;
   logic [15:0]    row_mem [DEF_MAX_SRC_WIDTH];
   logic [15:0]    left_px = 0, up_left_px = 0;
   int unsigned    col_cnt = 0, row_cnt = 0, next_row = 0, next_col = 0;

   pixel_in_type   pending_px[$];
   scaled_px_type  expected_px[$];
   pixel_in_type   drv_px;
   int             errors = 0;
   int unsigned    cycles = 0;
   int             burst_left = 0, gap_left = 0;
   int             stall_mode = 0;

   initial foreach (row_mem[i]) row_mem[i] = '0;

   function automatic void map_point(input int unsigned d, dsz, step, ssz,
                                     output int unsigned lo, hi, output longint frac);
      longint q, qmax;
      q = (longint'(d) - longint'(dsz / 2)) * longint'(step) + longint'(ssz / 2) * ONE;
      qmax = longint'(ssz - 1) * ONE;
      if (q < 0) q = 0;
      if (q > qmax) q = qmax;
      lo = 32'(q >> DEF_FRAC_BITS);
      frac = q & longint'(ONE - 1);
      hi = (lo + 1 < ssz) ? lo + 1 : ssz - 1;
   endfunction

   function automatic int unsigned col_high(int unsigned d, int unsigned w);
      int unsigned lo, hi;
      longint f;
      map_point(d, m_dst_w, m_step_x, w, lo, hi, f);
      return hi;
   endfunction

   function automatic int unsigned row_high(int unsigned d, int unsigned h);
      int unsigned lo, hi;
      longint f;
      map_point(d, m_dst_h, m_step_y, h, lo, hi, f);
      return hi;
   endfunction

   function automatic logic [7:0] interp(longint tl, tr, bl, br, fx, fy);
      longint top, bot, v;
      top = tl * (ONE - fx) + tr * fx;
      bot = bl * (ONE - fx) + br * fx;
      v = top * (ONE - fy) + bot * fy;
      return 8'(v >> (2 * DEF_FRAC_BITS));
   endfunction

   task automatic scale_pixel(input pixel_in_type px);
      int unsigned w, h, c, r, idx, nr, nc, ty, by, lx, rx;
      int unsigned rows[DEF_MAX_UPSCALE], cols[DEF_MAX_UPSCALE];
      longint fx, fy;
      logic [15:0] cur, up, tl, tr, bl, br;
      scaled_px_type e;
      int first;
      w = (m_src_w < 2) ? 2 : (m_src_w > DEF_MAX_SRC_WIDTH ? DEF_MAX_SRC_WIDTH : m_src_w);
      h = (m_src_h < 2) ? 2 : m_src_h;
      nr = 0;
      nc = 0;
      if (px.fs) begin
         col_cnt = 0; row_cnt = 0; next_row = 0; next_col = 0;
      end
      c = col_cnt;
      r = row_cnt;
      if (c == 0) next_col = 0;
      cur = {m_chroma ? px.b : 8'h00, px.a};
      idx = (c < DEF_MAX_SRC_WIDTH) ? c : DEF_MAX_SRC_WIDTH - 1;
      up = row_mem[idx];
      while (nr < DEF_MAX_UPSCALE && next_row + nr < m_dst_h &&
             row_high(next_row + nr, h) == r) begin
         rows[nr] = next_row + nr;
         nr++;
      end
      while (next_col < m_dst_w && col_high(next_col, w) <= c) begin
         if (col_high(next_col, w) == c && nc < DEF_MAX_UPSCALE) begin
            cols[nc] = next_col;
            nc++;
         end
         next_col++;
      end
      first = expected_px.size();
      for (int i = 0; i < nr; i++) begin
         map_point(rows[i], m_dst_h, m_step_y, h, ty, by, fy);
         for (int j = 0; j < nc; j++) begin
            map_point(cols[j], m_dst_w, m_step_x, w, lx, rx, fx);
            br = cur;
            bl = (lx == rx) ? cur : left_px;
            if (ty == by) begin
               tr = br; tl = bl;
            end else begin
               tr = up; tl = (lx == rx) ? up : up_left_px;
            end
            e.va = interp(tl[7:0], tr[7:0], bl[7:0], br[7:0], fx, fy);
            e.vb = m_chroma ? interp(tl[15:8], tr[15:8], bl[15:8], br[15:8], fx, fy) : 8'h00;
            e.col = DIM_W'(cols[j]);
            e.line = DIM_W'(rows[i]);
            e.last = 1'b0;
            expected_px.push_back(e);
         end
      end
      if (expected_px.size() > first) expected_px[$].last = 1'b1;
      row_mem[idx] = cur;
      up_left_px = up;
      left_px = cur;
      if (c + 1 >= w) begin
         col_cnt = 0;
         while (next_row < m_dst_h && row_high(next_row, h) <= r) next_row++;
         if (r + 1 >= h) begin
            row_cnt = 0; next_row = 0;
         end else begin
            row_cnt = r + 1;
         end
      end else begin
         col_cnt = c + 1;
      end
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      logic accepted;
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         accepted = req_tvalid && req_tready;
         if (accepted) begin
            scale_pixel(drv_px);
            void'(pending_px.pop_front());
         end
         if (!req_tvalid || accepted) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 0;
            end else if (pending_px.size() != 0) begin
               drv_px = pending_px[0];
               req_tvalid <= 1;
               req_tdata <= {drv_px.b, drv_px.a};
               req_tuser <= drv_px.fs;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
               end
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // receiver: stall pattern re-picked at random from four modes
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= (cycles % 8) < 2;
         default: rsp_tready <= ($urandom_range(0, 9) != 0);
      endcase
      if (cycles > CYC_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      scaled_px_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_px.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result item %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            e = expected_px.pop_front();
            if (rsp_tdata[7:0] !== e.va || rsp_tdata[15:8] !== e.vb ||
                rsp_tdata[28:16] !== e.col || rsp_tdata[41:29] !== e.line ||
                rsp_tlast !== e.last) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: exp a=%h b=%h col=%0d line=%0d last=%b, ",
                            "got a=%h b=%h col=%0d line=%0d last=%b"},
                           e.va, e.vb, e.col, e.line, e.last,
                           rsp_tdata[7:0], rsp_tdata[15:8],
                           rsp_tdata[28:16], rsp_tdata[41:29], rsp_tlast);
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_px.size() != 0 || req_tvalid || expected_px.size() != 0)
         @(posedge clock);
      // items with no result may still be in flight (row passes etc.)
      repeat (3 * (m_dst_w + m_dst_h) + 200) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned val);
      @(posedge clock);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= CSR_W'(val);
      case (idx)
         CSR_SRC_WIDTH:  m_src_w = val & 12'hFFF;
         CSR_SRC_HEIGHT: m_src_h = val & 12'hFFF;
         CSR_DST_WIDTH:  m_dst_w = val & 13'h1FFF;
         CSR_DST_HEIGHT: m_dst_h = val & 13'h1FFF;
         CSR_STEP_X:     m_step_x = val & 19'h7FFFF;
         CSR_STEP_Y:     m_step_y = val & 19'h7FFFF;
         default:        m_chroma = val & 1;
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic set_geometry(input int unsigned sw, sh, dw, dh, sx, sy, cm);
      wait_idle();
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_DST_WIDTH, dw);
      write_reg(CSR_DST_HEIGHT, dh);
      write_reg(CSR_STEP_X, sx);
      write_reg(CSR_STEP_Y, sy);
      write_reg(CSR_CHROMA_MODE, cm);
   endtask

   task automatic push_px(input logic [7:0] a, b, input logic fs);
      pixel_in_type p;
      p.a = a;
      p.b = b;
      p.fs = fs;
      pending_px.push_back(p);
   endtask

   task automatic push_plane(input int n, input logic mark);
      for (int i = 0; i < n; i++)
         push_px(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), mark && i == 0);
   endtask

   initial begin
      int sent, sw, sh, dw, dh, n;
      repeat (8) @(posedge clock);
      reset <= 0;

      // small upscale, luma, field extremes
      set_geometry(4, 3, 5, 4, 52429, 49152, 0);
      for (int i = 0; i < 12; i++)
         push_px((i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'hFF : 8'h00, i == 0);
      // chroma, 4x upscale: extra destination pixels dropped
      set_geometry(2, 2, 8, 8, 16384, 16384, 1);
      push_px(8'hFF, 8'h00, 1);
      push_px(8'h00, 8'hFF, 0);
      push_px(8'hAA, 8'h55, 0);
      push_px(8'h55, 8'hAA, 0);
      // plane shrinks mid-plane
      set_geometry(6, 4, 3, 3, 131072, 87381, 0);
      push_plane(5, 1);
      set_geometry(2, 2, 3, 3, 131072, 87381, 0);
      push_plane(3, 0);
      // empty destination
      set_geometry(3, 2, 0, 0, 65536, 65536, 0);
      push_plane(3, 1);
      // degenerate source and steps, largest destination
      set_geometry(0, 0, 8191, 8191, 0, 19'h7FFFF, 1);
      push_plane(4, 1);
      set_geometry(4095, 4095, 2, 2, 19'h7FFFF, 0, 0);
      push_plane(3, 1);

      // directed part above sends 34 items
      sent = 0;
      while (sent < 80) begin
         sw = $urandom_range(2, 8);
         sh = $urandom_range(2, 6);
         dw = $urandom_range(2, 12);
         dh = $urandom_range(2, 12);
         set_geometry(sw, sh, dw, dh,
                      (sw * ONE) / dw + $urandom_range(0, 4000) - 2000,
                      (sh * ONE) / dh + $urandom_range(0, 4000) - 2000,
                      $urandom_range(0, 1));
         repeat ($urandom_range(1, 2)) begin
            n = sw * sh;
            if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
            for (int i = 0; i < n; i++)
               push_px(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       i == 0 || $urandom_range(0, 40) == 0);
            sent += n;
         end
      end

      wait_idle();
      if (errors == 0 && expected_px.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
